// ===== sv/tcbf_pkg.sv =====
// ----------------------------------------------------------------------------
// tcbf_pkg
// Shared types and constants of the touch cell baseline filter.
// ----------------------------------------------------------------------------
package tcbf_pkg;

    // field widths of the channels
    localparam int KIND_W   = 1;
    localparam int ROW_W    = 4;
    localparam int COL_W    = 4;
    localparam int VALUE_W  = 16;
    localparam int SHIFT_W  = 3;
    localparam int GAIN_W   = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_UPDATE = 1'b0;
    localparam logic [KIND_W-1:0] KIND_SEED   = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_SHIFT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_GAIN  = 1'b1;

    // configuration reset values
    localparam logic [SHIFT_W-1:0] FAST_SHIFT_RST = 3'd1;
    localparam logic [GAIN_W-1:0]  SLOW_GAIN_RST  = 16'd328;

    // fixed-point fraction bits of the baseline gain
    localparam int GAIN_FRAC = 16;

    typedef struct packed {
        logic [SHIFT_W-1:0] fast_shift;
        logic [GAIN_W-1:0]  slow_gain;
    } t_cfg;

endpackage

// ===== sv/tcbf_in_if.sv =====
// ----------------------------------------------------------------------------
// tcbf_in_if
// Sample channel: one raw touch sample with its cell position.
// ----------------------------------------------------------------------------
interface tcbf_in_if;
    logic                         valid;
    logic                         ready;
    logic [tcbf_pkg::KIND_W-1:0]  kind;
    logic [tcbf_pkg::ROW_W-1:0]   row;
    logic [tcbf_pkg::COL_W-1:0]   col;
    logic [tcbf_pkg::VALUE_W-1:0] raw_sample;

    modport source (output valid, kind, row, col, raw_sample, input ready);
    modport sink   (input valid, kind, row, col, raw_sample, output ready);
endinterface

// ===== sv/tcbf_out_if.sv =====
// ----------------------------------------------------------------------------
// tcbf_out_if
// Result channel: new filtered value, baseline and delta of one cell.
// ----------------------------------------------------------------------------
interface tcbf_out_if;
    logic                         valid;
    logic                         ready;
    logic [tcbf_pkg::ROW_W-1:0]   out_row;
    logic [tcbf_pkg::COL_W-1:0]   out_col;
    logic [tcbf_pkg::VALUE_W-1:0] filtered_value;
    logic [tcbf_pkg::VALUE_W-1:0] baseline_value;
    logic [tcbf_pkg::VALUE_W-1:0] delta_value;

    modport source (output valid, out_row, out_col, filtered_value, baseline_value,
                    delta_value, input ready);
    modport sink   (input valid, out_row, out_col, filtered_value, baseline_value,
                    delta_value, output ready);
endinterface

// ===== sv/tcbf_cfg_if.sv =====
// ----------------------------------------------------------------------------
// tcbf_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface tcbf_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tcbf_pkg::CFG_IDX_W-1:0]  index;
    logic [tcbf_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/tcbf_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tcbf_cfg_regs
// Configuration registers: fast average shift and baseline gain.
// ----------------------------------------------------------------------------
module tcbf_cfg_regs (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tcbf_cfg_if.sink         i_cfg,
    output tcbf_pkg::t_cfg   o_cfg
);

    tcbf_pkg::t_cfg r_cfg;

    // take every write transaction at once
    assign i_cfg.ready = 1'b1;

    // update the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fast_shift <= tcbf_pkg::FAST_SHIFT_RST;
            r_cfg.slow_gain  <= tcbf_pkg::SLOW_GAIN_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                tcbf_pkg::CFG_FAST_SHIFT: begin
                    r_cfg.fast_shift <= i_cfg.data[tcbf_pkg::SHIFT_W-1:0];
                end
                tcbf_pkg::CFG_SLOW_GAIN: begin
                    r_cfg.slow_gain <= i_cfg.data[tcbf_pkg::GAIN_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/tcbf_cell_store.sv =====
// ----------------------------------------------------------------------------
// tcbf_cell_store
// Per-cell filtered and baseline memories, one read and one write port each.
// ----------------------------------------------------------------------------
module tcbf_cell_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_filt,
    output logic [DW-1:0] o_rd_base,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_filt,
    input  logic [DW-1:0] i_wr_base
);

    logic [DW-1:0] r_mem_filt [DEPTH];
    logic [DW-1:0] r_mem_base [DEPTH];
    logic [DW-1:0] r_rd_filt;
    logic [DW-1:0] r_rd_base;

    // registered read, returns the old entry on a same-edge write
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_filt <= r_mem_filt[i_rd_addr];
            r_rd_base <= r_mem_base[i_rd_addr];
        end
    end

    // write back both values of a cell
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_filt[i_wr_addr] <= i_wr_filt;
            r_mem_base[i_wr_addr] <= i_wr_base;
        end
    end

    assign o_rd_filt = r_rd_filt;
    assign o_rd_base = r_rd_base;

endmodule

// ===== sv/tcbf_pipe.sv =====
// ----------------------------------------------------------------------------
// tcbf_pipe
// Three-stage update pipeline: fast average, gain multiply, baseline step,
// with forwarding of values not yet visible in the memories.
// ----------------------------------------------------------------------------
module tcbf_pipe #(
    parameter int AW = 8,
    parameter int DW = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_adv,
    input  tcbf_pkg::t_cfg                 i_cfg,
    // accepted item
    input  logic                           i_acc,
    input  logic [tcbf_pkg::KIND_W-1:0]    i_kind,
    input  logic                           i_wr,
    input  logic [AW-1:0]                  i_addr,
    input  logic [tcbf_pkg::ROW_W-1:0]     i_row,
    input  logic [tcbf_pkg::COL_W-1:0]     i_col,
    input  logic [DW-1:0]                  i_raw,
    // memory read data
    input  logic [DW-1:0]                  i_rd_filt,
    input  logic [DW-1:0]                  i_rd_base,
    // status toward the input interlock and output register
    output logic                           o_s1_busy,
    output logic [AW-1:0]                  o_s1_addr,
    output logic                           o_s3_vld,
    // result of the last stage
    output logic [tcbf_pkg::ROW_W-1:0]     o_res_row,
    output logic [tcbf_pkg::COL_W-1:0]     o_res_col,
    output logic [tcbf_pkg::VALUE_W-1:0]   o_res_filt,
    output logic [tcbf_pkg::VALUE_W-1:0]   o_res_base,
    output logic [tcbf_pkg::VALUE_W-1:0]   o_res_delta,
    // memory write port
    output logic                           o_wr_en,
    output logic [AW-1:0]                  o_wr_addr,
    output logic [DW-1:0]                  o_wr_filt,
    output logic [DW-1:0]                  o_wr_base
);

    localparam int PW = DW + tcbf_pkg::GAIN_W + 2;

    // stage 1: read data arrives
    logic                          r_s1_vld;
    logic [tcbf_pkg::KIND_W-1:0]   r_s1_kind;
    logic                          r_s1_wr;
    logic [AW-1:0]                 r_s1_addr;
    logic [tcbf_pkg::ROW_W-1:0]    r_s1_row;
    logic [tcbf_pkg::COL_W-1:0]    r_s1_col;
    logic [DW-1:0]                 r_s1_raw;

    // stage 2: gain multiply
    logic                          r_s2_vld;
    logic [tcbf_pkg::KIND_W-1:0]   r_s2_kind;
    logic                          r_s2_wr;
    logic [AW-1:0]                 r_s2_addr;
    logic [tcbf_pkg::ROW_W-1:0]    r_s2_row;
    logic [tcbf_pkg::COL_W-1:0]    r_s2_col;
    logic [DW-1:0]                 r_s2_filt;
    logic [DW-1:0]                 r_s2_base;
    logic                          r_s2_bpend;

    // stage 3: baseline step and write back
    logic                          r_s3_vld;
    logic [tcbf_pkg::KIND_W-1:0]   r_s3_kind;
    logic                          r_s3_wr;
    logic [AW-1:0]                 r_s3_addr;
    logic [tcbf_pkg::ROW_W-1:0]    r_s3_row;
    logic [tcbf_pkg::COL_W-1:0]    r_s3_col;
    logic [DW-1:0]                 r_s3_filt;
    logic [DW-1:0]                 r_s3_base;
    logic signed [PW-1:0]          r_s3_prod;

    // copy of the last write, covers reads taken on the same edge
    logic                          r_wb_vld;
    logic [AW-1:0]                 r_wb_addr;
    logic [DW-1:0]                 r_wb_filt;
    logic [DW-1:0]                 r_wb_base;

    logic                          s1_hit3;
    logic                          s1_hitw;
    logic [DW-1:0]                 s1_filt_cur;
    logic [DW-1:0]                 s1_base_cur;
    logic signed [DW:0]            s1_diff;
    logic signed [DW:0]            s1_step;
    logic signed [DW:0]            s1_sum;
    logic [DW-1:0]                 n_s2_filt;

    logic [DW-1:0]                 s2_base;
    logic signed [DW:0]            s2_diff;
    logic signed [PW-1:0]          n_s3_prod;

    logic signed [PW-1:0]          s3_prod_sh;
    logic signed [DW:0]            s3_sum;
    logic [DW-1:0]                 s3_base;
    logic [DW:0]                   s3_gap;
    logic [DW-1:0]                 s3_delta;

    // stage 1: resolve the current filtered value and baseline of the cell
    always_comb begin
        s1_hit3     = r_s3_vld && r_s3_wr && (r_s3_addr == r_s1_addr);
        s1_hitw     = r_wb_vld && (r_wb_addr == r_s1_addr);
        s1_filt_cur = s1_hit3 ? r_s3_filt : (s1_hitw ? r_wb_filt : i_rd_filt);
        s1_base_cur = s1_hitw ? r_wb_base : i_rd_base;
    end

    // stage 1: fast average, arithmetic shift gives the floor
    always_comb begin
        s1_diff = $signed({1'b0, r_s1_raw}) - $signed({1'b0, s1_filt_cur});
        s1_step = s1_diff >>> i_cfg.fast_shift;
        s1_sum  = $signed({1'b0, s1_filt_cur}) + s1_step;
        if (r_s1_kind == tcbf_pkg::KIND_SEED) begin
            n_s2_filt = r_s1_raw;
        end else begin
            n_s2_filt = s1_sum[DW-1:0];
        end
    end

    // stage 2: baseline of a cell still in the last stage comes from the write copy
    always_comb begin
        s2_base   = r_s2_bpend ? r_wb_base : r_s2_base;
        s2_diff   = $signed({1'b0, r_s2_filt}) - $signed({1'b0, s2_base});
        n_s3_prod = $signed({1'b0, i_cfg.slow_gain}) * s2_diff;
    end

    // stage 3: baseline step with floor, then the positive delta
    always_comb begin
        s3_prod_sh = r_s3_prod >>> tcbf_pkg::GAIN_FRAC;
        s3_sum     = $signed({1'b0, r_s3_base}) + $signed(s3_prod_sh[DW:0]);
        if (r_s3_kind == tcbf_pkg::KIND_SEED) begin
            s3_base = r_s3_filt;
        end else begin
            s3_base = s3_sum[DW-1:0];
        end
        s3_gap   = {1'b0, r_s3_filt} - {1'b0, s3_base};
        s3_delta = s3_gap[DW] ? '0 : s3_gap[DW-1:0];
    end

    // advance the pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_wb_vld <= 1'b0;
        end else if (i_adv) begin
            r_s1_vld <= i_acc;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_wb_vld <= r_s3_vld && r_s3_wr;
        end
    end

    // advance the pipeline payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s1_kind  <= i_kind;
            r_s1_wr    <= i_wr;
            r_s1_addr  <= i_addr;
            r_s1_row   <= i_row;
            r_s1_col   <= i_col;
            r_s1_raw   <= i_raw;

            r_s2_kind  <= r_s1_kind;
            r_s2_wr    <= r_s1_wr;
            r_s2_addr  <= r_s1_addr;
            r_s2_row   <= r_s1_row;
            r_s2_col   <= r_s1_col;
            r_s2_filt  <= n_s2_filt;
            r_s2_base  <= s1_base_cur;
            r_s2_bpend <= s1_hit3;

            r_s3_kind  <= r_s2_kind;
            r_s3_wr    <= r_s2_wr;
            r_s3_addr  <= r_s2_addr;
            r_s3_row   <= r_s2_row;
            r_s3_col   <= r_s2_col;
            r_s3_filt  <= r_s2_filt;
            r_s3_base  <= s2_base;
            r_s3_prod  <= n_s3_prod;

            r_wb_addr  <= r_s3_addr;
            r_wb_filt  <= r_s3_filt;
            r_wb_base  <= s3_base;
        end
    end

    assign o_s1_busy = r_s1_vld && r_s1_wr;
    assign o_s1_addr = r_s1_addr;
    assign o_s3_vld  = r_s3_vld;

    // cells outside the matrix report zero values
    assign o_res_row   = r_s3_row;
    assign o_res_col   = r_s3_col;
    assign o_res_filt  = r_s3_wr ? tcbf_pkg::VALUE_W'(r_s3_filt) : '0;
    assign o_res_base  = r_s3_wr ? tcbf_pkg::VALUE_W'(s3_base) : '0;
    assign o_res_delta = r_s3_wr ? tcbf_pkg::VALUE_W'(s3_delta) : '0;

    assign o_wr_en   = i_adv && r_s3_vld && r_s3_wr;
    assign o_wr_addr = r_s3_addr;
    assign o_wr_filt = r_s3_filt;
    assign o_wr_base = s3_base;

endmodule

// ===== sv/touch_cell_baseline_filter.sv =====
// ----------------------------------------------------------------------------
// touch_cell_baseline_filter
// Per-cell fast average and slow baseline tracking for a touch matrix.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one raw sample per transaction with its row, column and kind
//   (seed loads both stored values of the cell, update filters). o_out returns
//   one result per sample, in order: filtered value, baseline and the positive
//   part of their difference. Samples outside ROWS x COLS leave the state
//   untouched and report zero values. i_cfg writes the fast shift (index 0)
//   and the baseline gain (index 1); write it only while the block is idle.
// Timing:
//   A result passes through a 3-stage pipeline and an output register. One
//   sample is taken per cycle unless the output stalls or a hazard holds it.
//   An update of the cell taken just before is held while that cell is in
//   stage 1, as its values are written back through the memory port only later.
// Reset:
//   Clears the pipeline and the configuration, not the cell memories: the user
//   must seed every cell before its first update; the block does not enforce it.
// Stall:
//   While o_out holds a result that is not taken, the pipeline keeps moving
//   only into empty slots and the input stops once the last stage is full.
// ----------------------------------------------------------------------------
module touch_cell_baseline_filter #(
    parameter int ROWS        = 16,
    parameter int COLS        = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tcbf_in_if.sink      i_in,
    tcbf_cfg_if.sink     i_cfg,
    tcbf_out_if.source   o_out
);

    localparam int CELLS = ROWS * COLS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int DW    = (SAMPLE_BITS < tcbf_pkg::VALUE_W) ? SAMPLE_BITS
                                                              : tcbf_pkg::VALUE_W;

    tcbf_pkg::t_cfg                 cfg;

    logic                           in_range;
    logic [AW-1:0]                  in_addr;
    logic                           hazard;
    logic                           adv;
    logic                           out_en;
    logic                           acc;

    logic [DW-1:0]                  rd_filt;
    logic [DW-1:0]                  rd_base;
    logic                           s1_busy;
    logic [AW-1:0]                  s1_addr;
    logic                           s3_vld;
    logic [tcbf_pkg::ROW_W-1:0]     res_row;
    logic [tcbf_pkg::COL_W-1:0]     res_col;
    logic [tcbf_pkg::VALUE_W-1:0]   res_filt;
    logic [tcbf_pkg::VALUE_W-1:0]   res_base;
    logic [tcbf_pkg::VALUE_W-1:0]   res_delta;
    logic                           wr_en;
    logic [AW-1:0]                  wr_addr;
    logic [DW-1:0]                  wr_filt;
    logic [DW-1:0]                  wr_base;

    logic                           r_out_vld;
    logic [tcbf_pkg::ROW_W-1:0]     r_out_row;
    logic [tcbf_pkg::COL_W-1:0]     r_out_col;
    logic [tcbf_pkg::VALUE_W-1:0]   r_out_filt;
    logic [tcbf_pkg::VALUE_W-1:0]   r_out_base;
    logic [tcbf_pkg::VALUE_W-1:0]   r_out_delta;

    // cell index of the incoming sample
    always_comb begin
        in_range = (32'(i_in.row) < ROWS) && (32'(i_in.col) < COLS);
        in_addr  = in_range ? AW'(32'(i_in.row) * COLS + 32'(i_in.col)) : '0;
    end

    // hold an update of the cell that is one stage ahead
    assign hazard = (i_in.kind == tcbf_pkg::KIND_UPDATE) && in_range && s1_busy
                    && (s1_addr == in_addr);

    // advance when the output register frees up or the last stage is empty
    assign out_en     = !r_out_vld || o_out.ready;
    assign adv        = out_en || !s3_vld;
    assign i_in.ready = adv && !hazard;
    assign acc        = i_in.valid && i_in.ready;

    tcbf_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    tcbf_cell_store #(
        .DEPTH (CELLS),
        .AW    (AW),
        .DW    (DW)
    ) u_cell_store (
        .i_clk     (i_clk),
        .i_rd_en   (adv),
        .i_rd_addr (in_addr),
        .o_rd_filt (rd_filt),
        .o_rd_base (rd_base),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_filt (wr_filt),
        .i_wr_base (wr_base)
    );

    tcbf_pipe #(
        .AW (AW),
        .DW (DW)
    ) u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_cfg       (cfg),
        .i_acc       (acc),
        .i_kind      (i_in.kind),
        .i_wr        (in_range),
        .i_addr      (in_addr),
        .i_row       (i_in.row),
        .i_col       (i_in.col),
        .i_raw       (i_in.raw_sample[DW-1:0]),
        .i_rd_filt   (rd_filt),
        .i_rd_base   (rd_base),
        .o_s1_busy   (s1_busy),
        .o_s1_addr   (s1_addr),
        .o_s3_vld    (s3_vld),
        .o_res_row   (res_row),
        .o_res_col   (res_col),
        .o_res_filt  (res_filt),
        .o_res_base  (res_base),
        .o_res_delta (res_delta),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_filt   (wr_filt),
        .o_wr_base   (wr_base)
    );

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_en) begin
            r_out_vld <= s3_vld;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (out_en && s3_vld) begin
            r_out_row   <= res_row;
            r_out_col   <= res_col;
            r_out_filt  <= res_filt;
            r_out_base  <= res_base;
            r_out_delta <= res_delta;
        end
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.out_row        = r_out_row;
    assign o_out.out_col        = r_out_col;
    assign o_out.filtered_value = r_out_filt;
    assign o_out.baseline_value = r_out_base;
    assign o_out.delta_value    = r_out_delta;

    // a write back always hands its transaction to the output register
    a_wr_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> r_out_vld)
        else $error("write back without a result in the output register");

    // the delta never exceeds the filtered value
    a_delta_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.delta_value <= o_out.filtered_value))
        else $error("delta larger than filtered value");

    // no update is taken while the same cell sits one stage ahead
    a_no_adjacent_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_in.kind == tcbf_pkg::KIND_UPDATE) && in_range && s1_busy)
        |-> (s1_addr != in_addr))
        else $error("update taken over a pending write of the same cell");

    // a full output register that is not taken holds while the last stage is busy
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_out.ready && s3_vld) |-> !adv)
        else $error("pipeline advanced over a stalled result");

endmodule

// ===== sim/touch_cell_baseline_filter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_cell_baseline_filter_test
// Self-checking bench for the per-cell touch baseline filter. A short table of
// seeds and updates on corner and centre cells runs first, then random scan
// traffic under several gain settings. Every result is checked against a typed
// table value or a local model of the fast average and slow baseline per cell.
// ----------------------------------------------------------------------------
module touch_cell_baseline_filter_test;

    localparam int ROWS       = 16;
    localparam int COLS       = 16;
    localparam int CELLS      = ROWS * COLS;
    localparam int PHASES     = 6;
    localparam int RAND_ITEMS = 172;
    localparam int SETTLE     = 8;
    localparam int MAX_REPORT = 10;

    typedef struct packed {
        logic [tcbf_pkg::ROW_W-1:0]   row;
        logic [tcbf_pkg::COL_W-1:0]   col;
        logic [tcbf_pkg::VALUE_W-1:0] filt;
        logic [tcbf_pkg::VALUE_W-1:0] base;
        logic [tcbf_pkg::VALUE_W-1:0] delta;
    } t_cell_result;

    typedef struct packed {
        logic [tcbf_pkg::KIND_W-1:0]  kind;
        logic [tcbf_pkg::ROW_W-1:0]   row;
        logic [tcbf_pkg::COL_W-1:0]   col;
        logic [tcbf_pkg::VALUE_W-1:0] raw;
        logic                         typed;
        logic [tcbf_pkg::VALUE_W-1:0] filt;
        logic [tcbf_pkg::VALUE_W-1:0] base;
        logic [tcbf_pkg::VALUE_W-1:0] delta;
    } t_scan_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tcbf_in_if  sample_if ();
    tcbf_cfg_if cfg_if ();
    tcbf_out_if result_if ();

    touch_cell_baseline_filter #(
        .ROWS        (ROWS),
        .COLS        (COLS),
        .SAMPLE_BITS (16)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (sample_if),
        .i_cfg   (cfg_if),
        .o_out   (result_if)
    );

    // model state: per-cell values and the active gains
    logic [tcbf_pkg::VALUE_W-1:0] filt_mem [CELLS];
    logic [tcbf_pkg::VALUE_W-1:0] base_mem [CELLS];
    bit                           cell_seeded [CELLS];
    logic [tcbf_pkg::SHIFT_W-1:0] fast_shift_q = tcbf_pkg::FAST_SHIFT_RST;
    logic [tcbf_pkg::GAIN_W-1:0]  slow_gain_q  = tcbf_pkg::SLOW_GAIN_RST;

    t_cell_result pending_results[$];
    int           mismatch_count = 0;
    int           stall_left = 0;
    bit           idle_enable = 1'b1;
    logic [7:0]   hot_cell [4];

    // corner cells: seeds and updates read straight off the arithmetic are typed in
    t_scan_row scan_tab [20] = '{
        '{tcbf_pkg::KIND_SEED,   4'd0,  4'd0,  16'h0000, 1'b1, 16'h0000, 16'h0000, 16'h0000},
        '{tcbf_pkg::KIND_SEED,   4'd15, 4'd15, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'h0000},
        '{tcbf_pkg::KIND_SEED,   4'd0,  4'd15, 16'h5555, 1'b1, 16'h5555, 16'h5555, 16'h0000},
        '{tcbf_pkg::KIND_SEED,   4'd15, 4'd0,  16'hAAAA, 1'b1, 16'hAAAA, 16'hAAAA, 16'h0000},
        '{tcbf_pkg::KIND_UPDATE, 4'd0,  4'd0,  16'hFFFF, 1'b0, 16'h0000, 16'h0000, 16'h0000},
        '{tcbf_pkg::KIND_UPDATE, 4'd0,  4'd0,  16'hFFFF, 1'b0, 16'h0000, 16'h0000, 16'h0000},
        '{tcbf_pkg::KIND_UPDATE, 4'd0,  4'd0,  16'hFFFF, 1'b0, 16'h0000, 16'h0000, 16'h0000},
        '{tcbf_pkg::KIND_UPDATE, 4'd15, 4'd15, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000},
        '{tcbf_pkg::KIND_UPDATE, 4'd15, 4'd15, 16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000},
        '{tcbf_pkg::KIND_UPDATE, 4'd0,  4'd15, 16'h5555, 1'b1, 16'h5555, 16'h5555, 16'h0000},
        '{tcbf_pkg::KIND_UPDATE, 4'd15, 4'd0,  16'hAAA9, 1'b0, 16'h0000, 16'h0000, 16'h0000},
        '{tcbf_pkg::KIND_UPDATE, 4'd15, 4'd0,  16'hAAAA, 1'b0, 16'h0000, 16'h0000, 16'h0000},
        '{tcbf_pkg::KIND_SEED,   4'd7,  4'd8,  16'h1234, 1'b1, 16'h1234, 16'h1234, 16'h0000},
        '{tcbf_pkg::KIND_UPDATE, 4'd7,  4'd8,  16'hFFFF, 1'b0, 16'h0000, 16'h0000, 16'h0000},
        '{tcbf_pkg::KIND_SEED,   4'd8,  4'd7,  16'h8000, 1'b1, 16'h8000, 16'h8000, 16'h0000},
        '{tcbf_pkg::KIND_UPDATE, 4'd8,  4'd7,  16'h7FFF, 1'b0, 16'h0000, 16'h0000, 16'h0000},
        '{tcbf_pkg::KIND_UPDATE, 4'd0,  4'd0,  16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000},
        '{tcbf_pkg::KIND_UPDATE, 4'd15, 4'd15, 16'hFFFF, 1'b0, 16'h0000, 16'h0000, 16'h0000},
        '{tcbf_pkg::KIND_SEED,   4'd0,  4'd0,  16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'h0000},
        '{tcbf_pkg::KIND_UPDATE, 4'd0,  4'd0,  16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000}
    };

    // clock: 2 ns period
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // advance one cell: fast average toward the sample, then baseline toward it
    function automatic t_cell_result track_cell(
        input logic [tcbf_pkg::KIND_W-1:0]  kind,
        input logic [tcbf_pkg::ROW_W-1:0]   row,
        input logic [tcbf_pkg::COL_W-1:0]   col,
        input logic [tcbf_pkg::VALUE_W-1:0] raw);
        t_cell_result res;
        int           idx;
        longint       f;
        longint       b;
        res = '0;
        res.row = row;
        res.col = col;
        // cells outside the matrix leave state alone and report zeros
        if (row < ROWS && col < COLS) begin
            idx = row * COLS + col;
            if (kind == tcbf_pkg::KIND_SEED) begin
                filt_mem[idx] = raw;
                base_mem[idx] = raw;
                cell_seeded[idx] = 1'b1;
                res.filt = raw;
                res.base = raw;
            end else begin
                f = filt_mem[idx];
                b = base_mem[idx];
                // arithmetic shifts of signed differences floor toward minus infinity
                f = f + ((longint'(raw) - f) >>> fast_shift_q);
                b = b + ((longint'(slow_gain_q) * (f - b)) >>> tcbf_pkg::GAIN_FRAC);
                filt_mem[idx] = f[tcbf_pkg::VALUE_W-1:0];
                base_mem[idx] = b[tcbf_pkg::VALUE_W-1:0];
                res.filt  = f[tcbf_pkg::VALUE_W-1:0];
                res.base  = b[tcbf_pkg::VALUE_W-1:0];
                res.delta = (f > b) ? tcbf_pkg::VALUE_W'(f - b) : '0;
            end
        end
        return res;
    endfunction

    // present one sample, hold it until taken, then queue its expected result
    task automatic send_sample(input logic [tcbf_pkg::KIND_W-1:0]  kind,
                               input logic [tcbf_pkg::ROW_W-1:0]   row,
                               input logic [tcbf_pkg::COL_W-1:0]   col,
                               input logic [tcbf_pkg::VALUE_W-1:0] raw,
                               input logic typed, input t_cell_result typed_res);
        t_cell_result res;
        if (idle_enable && $urandom_range(99) < 20) begin
            sample_if.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        sample_if.valid      <= 1'b1;
        sample_if.kind       <= kind;
        sample_if.row        <= row;
        sample_if.col        <= col;
        sample_if.raw_sample <= raw;
        do @(posedge i_clk); while (!sample_if.ready);
        res = track_cell(kind, row, col, raw);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    // write both gains back to back, then drop the write strobe
    task automatic set_gains(input logic [tcbf_pkg::SHIFT_W-1:0] shift,
                             input logic [tcbf_pkg::GAIN_W-1:0]  gain);
        logic [tcbf_pkg::CFG_IDX_W-1:0]  idx;
        logic [tcbf_pkg::CFG_DATA_W-1:0] data;
        for (int i = 0; i < 2; i++) begin
            idx  = (i == 0) ? tcbf_pkg::CFG_FAST_SHIFT : tcbf_pkg::CFG_SLOW_GAIN;
            data = (i == 0) ? tcbf_pkg::CFG_DATA_W'(shift) : gain;
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idx;
            cfg_if.data  <= data;
            do @(posedge i_clk); while (!cfg_if.ready);
            case (idx)
                tcbf_pkg::CFG_FAST_SHIFT: begin
                    fast_shift_q = data[tcbf_pkg::SHIFT_W-1:0];
                end
                tcbf_pkg::CFG_SLOW_GAIN: begin
                    slow_gain_q = data[tcbf_pkg::GAIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
        cfg_if.valid <= 1'b0;
    endtask

    // drop valid and wait for the pipeline to empty
    task automatic drain();
        sample_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // random scan traffic: mostly updates of seeded cells, a hot few back to back
    task automatic scan_random(input int count);
        logic [7:0]                   cell_idx;
        logic [tcbf_pkg::KIND_W-1:0]  kind;
        logic [tcbf_pkg::VALUE_W-1:0] raw;
        int                           near;
        int                           pick;
        for (int k = 0; k < 4; k++) hot_cell[k] = 8'($urandom_range(CELLS - 1));
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 40) cell_idx = hot_cell[$urandom_range(3)];
            else cell_idx = 8'($urandom_range(CELLS - 1));
            // never update a cell whose stored values were never written
            if (!cell_seeded[cell_idx] || $urandom_range(99) < 12) kind = tcbf_pkg::KIND_SEED;
            else kind = tcbf_pkg::KIND_UPDATE;
            pick = $urandom_range(99);
            if (pick < 8) begin
                raw = '0;
            end else if (pick < 16) begin
                raw = '1;
            end else if (pick < 56 && cell_seeded[cell_idx]) begin
                near = int'(filt_mem[cell_idx]) + int'($urandom_range(600)) - 300;
                if (near < 0) near = 0;
                if (near > 65535) near = 65535;
                raw = tcbf_pkg::VALUE_W'(near);
            end else begin
                raw = tcbf_pkg::VALUE_W'($urandom);
            end
            send_sample(kind, cell_idx[7:4], cell_idx[3:0], raw, 1'b0, '0);
        end
    endtask

    // result side: compare each transaction and stall in random bursts
    always @(posedge i_clk) begin
        t_cell_result got;
        t_cell_result want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            got.row   = result_if.out_row;
            got.col   = result_if.out_col;
            got.filt  = result_if.filtered_value;
            got.base  = result_if.baseline_value;
            got.delta = result_if.delta_value;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORT)
                    $display("%0t: unexpected result cell (%0d,%0d) filt %h base %h delta %h",
                             $realtime, got.row, got.col, got.filt, got.base, got.delta);
            end else begin
                want = pending_results.pop_front();
                if (got.row !== want.row || got.col !== want.col || got.filt !== want.filt ||
                    got.base !== want.base || got.delta !== want.delta) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORT)
                        $display("%0t: cell (%0d,%0d) filt %h base %h delta %h, got (%0d,%0d) %s",
                                 $realtime, want.row, want.col, want.filt, want.base,
                                 want.delta, got.row, got.col,
                                 $sformatf("filt %h base %h delta %h",
                                           got.filt, got.base, got.delta));
                end
            end
        end
        if (stall_left != 0) begin
            stall_left      <= stall_left - 1;
            result_if.ready <= 1'b0;
        end else if (idle_enable && $urandom_range(99) < 15) begin
            stall_left      <= $urandom_range(1, 13) - 1;
            result_if.ready <= 1'b0;
        end else begin
            result_if.ready <= 1'b1;
        end
    end

    // main sequence
    initial begin
        t_cell_result typed_res;
        sample_if.valid      = 1'b0;
        sample_if.kind       = tcbf_pkg::KIND_UPDATE;
        sample_if.row        = '0;
        sample_if.col        = '0;
        sample_if.raw_sample = '0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = tcbf_pkg::CFG_FAST_SHIFT;
        cfg_if.data          = '0;
        result_if.ready      = 1'b0;
        for (int i = 0; i < CELLS; i++) cell_seeded[i] = 1'b0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corner cells under the reset gains
        foreach (scan_tab[i]) begin
            typed_res = '{scan_tab[i].row, scan_tab[i].col, scan_tab[i].filt,
                          scan_tab[i].base, scan_tab[i].delta};
            send_sample(scan_tab[i].kind, scan_tab[i].row, scan_tab[i].col,
                        scan_tab[i].raw, scan_tab[i].typed, typed_res);
        end
        scan_random(RAND_ITEMS);

        // further gain settings, extremes first; the last phase runs without gaps
        for (int p = 1; p < PHASES; p++) begin
            drain();
            case (p)
                1: set_gains('0, '0);
                2: set_gains('1, '1);
                3: set_gains(tcbf_pkg::SHIFT_W'($urandom_range(7)),
                             tcbf_pkg::GAIN_W'($urandom_range(65535)));
                4: set_gains(3'd2, 16'd16384);
                default: set_gains(tcbf_pkg::SHIFT_W'($urandom_range(1, 6)),
                                   tcbf_pkg::GAIN_W'($urandom_range(65535)));
            endcase
            if (p == PHASES - 1) idle_enable = 1'b0;
            scan_random(RAND_ITEMS);
        end
        drain();

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog
    initial begin
        #400000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
